// ----- rtl/open_file_table_allocator_defines.svh -----
// Assertion macros for the open file table allocator.
// Each macro checks on the rising edge of i_clk and is held off while reset is low.
`ifndef OPEN_FILE_TABLE_ALLOCATOR_DEFINES_SVH
`define OPEN_FILE_TABLE_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OFT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("open file table allocator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("open file table allocator: next-cycle check failed");

`endif

// ----- rtl/oft_pkg.sv -----
package oft_pkg;

    // Table sizes.
    localparam int DESCRIPTORS  = 32;
    localparam int FILE_ENTRIES = 64;

    // Derived widths. A head pointer carries one extra bit for the null value.
    localparam int DESC_W = $clog2(DESCRIPTORS);
    localparam int ENT_W  = $clog2(FILE_ENTRIES);
    localparam int HEAD_W = ENT_W + 1;

    // Stream field widths.
    localparam int IN_DESC_W   = 8;
    localparam int IN_ENT_W    = 7;
    localparam int DATA_W      = 16;
    localparam int STATUS_W    = 3;
    localparam int ACTION_W    = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = STATUS_W + 1;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (DESC_W + ENT_W + 2 * DATA_W);

    // Requested operation.
    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_CLOSE  = 2'd1,
        ACT_LOOKUP = 2'd2
    } t_action;

    // Result status codes.
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BADF      = 3'd1;
    localparam t_status ST_NODESC    = 3'd2;
    localparam t_status ST_TABLEFULL = 3'd3;
    localparam t_status ST_IGNORED   = 3'd4;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC_RD,
        S_CLOSE_CHK,
        S_CLOSE_RD,
        S_LOOK_CHK,
        S_LOOK_BIND,
        S_LOOK_ENT,
        S_DONE
    } t_state;

    // Report of the descriptor scanner.
    typedef struct packed {
        logic              done;
        logic              found;
        logic [DESC_W-1:0] idx;
    } t_scan_res;

endpackage

// ----- rtl/oft_scan.sv -----
module oft_scan import oft_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DESCRIPTORS-1:0] i_bound,
    output t_scan_res              o_res
);

    logic              r_busy;
    logic [DESC_W-1:0] r_cnt;
    logic              hit;
    logic              last;

    // One descriptor is tested per cycle, lowest first.
    assign hit  = r_busy && !i_bound[r_cnt];
    assign last = (r_cnt == DESC_W'(DESCRIPTORS - 1));

    assign o_res.done  = r_busy && (hit || last);
    assign o_res.found = hit;
    assign o_res.idx   = r_cnt;

    // Scan counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (hit || last) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/open_file_table_allocator.sv -----
// Channel   Direction  tdata fields (low bit up)                     tuser fields
// s_axis    in         descriptor_in, entry_in, inode_handle_in,     action
//                      open_flags_in
// m_axis    out        descriptor_out, entry_out, inode_handle_out,  status, release_inode
//                      open_flags_out
//
// Allocate runs a scanner that tests one descriptor per cycle, up to 32, then a commit step.
// Close runs a range check and then, if it passes, a registered entry read; lookup runs a
// range check and then two registered memory reads in series; an unknown action goes to done.
// Reset is synchronous and active low; it empties all bindings and rebuilds the free list
// at once through per-entry valid bits, so no clearing pass is needed.
// One transaction is worked at a time. A result waits in the output register while
// the next transaction is accepted; a stalled output holds back the next result and new input.
`include "open_file_table_allocator_defines.svh"

module open_file_table_allocator import oft_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // descriptor_in [7:0], entry_in [14:8], inode_handle_in [30:15],
    // open_flags_in [46:31], zero pad [47]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action [1:0]
    input  logic [ACTION_W-1:0]    s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // descriptor_out [4:0], entry_out [10:5], inode_handle_out [26:11],
    // open_flags_out [42:27], zero pad [47:43]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status [2:0], release_inode [3]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // Control state.
    t_state                  r_state;
    t_state                  n_state;
    logic [HEAD_W-1:0]       r_head;
    logic [DESCRIPTORS-1:0]  r_bound;
    logic [FILE_ENTRIES-1:0] r_used;
    logic [FILE_ENTRIES-1:0] r_nf_valid;
    logic                    r_out_valid;

    // Latched input transaction.
    logic [IN_DESC_W-1:0]    r_in_desc;
    logic [IN_ENT_W-1:0]     r_in_entry;
    logic [DATA_W-1:0]       r_in_inode;
    logic [DATA_W-1:0]       r_in_flags;

    // Result staging and output registers.
    t_status                 r_res_status;
    logic [DESC_W-1:0]       r_res_desc;
    logic [ENT_W-1:0]        r_res_entry;
    logic [DATA_W-1:0]       r_res_inode;
    logic [DATA_W-1:0]       r_res_flags;
    logic                    r_res_rel;
    t_status                 r_out_status;
    logic [DESC_W-1:0]       r_out_desc;
    logic [ENT_W-1:0]        r_out_entry;
    logic [DATA_W-1:0]       r_out_inode;
    logic [DATA_W-1:0]       r_out_flags;
    logic                    r_out_rel;

    // Memories.
    logic [ENT_W-1:0]        mem_bind   [DESCRIPTORS];
    logic [HEAD_W-1:0]       mem_next   [FILE_ENTRIES];
    logic [DATA_W-1:0]       mem_inode  [FILE_ENTRIES];
    logic [DATA_W-1:0]       mem_flags  [FILE_ENTRIES];
    logic [ENT_W-1:0]        r_bind_q;
    logic [HEAD_W-1:0]       r_nf_mem_q;
    logic                    r_nf_v_q;
    logic [HEAD_W-1:0]       r_nf_dflt_q;
    logic [DATA_W-1:0]       r_inode_q;
    logic [DATA_W-1:0]       r_flags_q;

    // Combinational control.
    logic                    in_accept;
    t_action                 in_action;
    logic                    scan_start;
    t_scan_res               scan_res;
    logic                    head_null;
    logic [ENT_W-1:0]        head_idx;
    logic [ENT_W-1:0]        entry_idx;
    logic [DESC_W-1:0]       desc_idx;
    logic                    close_ok;
    logic                    look_ok;
    logic [HEAD_W-1:0]       nf_next;
    logic [ENT_W-1:0]        ent_rd_addr;
    logic                    alloc_commit;
    logic                    close_commit;
    logic                    out_load;
    logic                    res_load;
    t_status                 n_res_status;
    logic [DESC_W-1:0]       n_res_desc;
    logic [ENT_W-1:0]        n_res_entry;
    logic [DATA_W-1:0]       n_res_inode;
    logic [DATA_W-1:0]       n_res_flags;
    logic                    n_res_rel;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_action = t_action'(s_axis_tuser);
    assign head_null = (r_head >= HEAD_W'(FILE_ENTRIES));
    assign head_idx  = r_head[ENT_W-1:0];
    assign entry_idx = r_in_entry[ENT_W-1:0];
    assign desc_idx  = r_in_desc[DESC_W-1:0];
    assign close_ok  = (32'(r_in_entry) < FILE_ENTRIES) && r_used[entry_idx];
    assign look_ok   = (32'(r_in_desc) < DESCRIPTORS) && r_bound[desc_idx];
    assign nf_next   = r_nf_v_q ? r_nf_mem_q : r_nf_dflt_q;

    // Lowest free descriptor search.
    oft_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_bound (r_bound),
        .o_res   (scan_res)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (in_action)
                        ACT_ALLOC:  n_state = S_SCAN;
                        ACT_CLOSE:  n_state = S_CLOSE_CHK;
                        ACT_LOOKUP: n_state = S_LOOK_CHK;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    n_state = (scan_res.found && !head_null) ? S_ALLOC_RD : S_DONE;
                end
            end
            S_ALLOC_RD:  n_state = S_DONE;
            S_CLOSE_CHK: n_state = close_ok ? S_CLOSE_RD : S_DONE;
            S_CLOSE_RD:  n_state = S_DONE;
            S_LOOK_CHK:  n_state = look_ok ? S_LOOK_BIND : S_DONE;
            S_LOOK_BIND: n_state = S_LOOK_ENT;
            S_LOOK_ENT:  n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: strobes, read address and the result of each step.
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        scan_start    = 1'b0;
        alloc_commit  = 1'b0;
        close_commit  = 1'b0;
        out_load      = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
        ent_rd_addr   = entry_idx;
        res_load      = 1'b0;
        n_res_status  = ST_IGNORED;
        n_res_desc    = '0;
        n_res_entry   = '0;
        n_res_inode   = '0;
        n_res_flags   = '0;
        n_res_rel     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    scan_start = (in_action == ACT_ALLOC);
                    res_load   = 1'b1;
                end
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    res_load     = 1'b1;
                    n_res_status = !scan_res.found ? ST_NODESC : ST_TABLEFULL;
                end
            end
            S_ALLOC_RD: begin
                alloc_commit = 1'b1;
                res_load     = 1'b1;
                n_res_status = ST_OK;
                n_res_desc   = r_res_desc;
                n_res_entry  = head_idx;
            end
            S_CLOSE_CHK: begin
                close_commit = close_ok;
                res_load     = 1'b1;
            end
            S_CLOSE_RD: begin
                res_load     = 1'b1;
                n_res_status = ST_OK;
                n_res_entry  = entry_idx;
                n_res_inode  = r_inode_q;
                n_res_rel    = 1'b1;
            end
            S_LOOK_CHK: begin
                res_load     = 1'b1;
                n_res_status = ST_BADF;
            end
            S_LOOK_BIND: begin
                ent_rd_addr  = r_bind_q;
            end
            S_LOOK_ENT: begin
                res_load     = 1'b1;
                n_res_status = ST_OK;
                n_res_entry  = r_bind_q;
                n_res_inode  = r_inode_q;
                n_res_flags  = r_flags_q;
            end
            default: begin
                res_load = 1'b0;
            end
        endcase
    end

    // Control registers: state, free list head, occupancy bits, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_bound     <= '0;
            r_used      <= '0;
            r_nf_valid  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (alloc_commit) begin
                r_head             <= nf_next;
                r_bound[r_res_desc] <= 1'b1;
                r_used[head_idx]   <= 1'b1;
            end
            if (close_commit) begin
                r_head                <= HEAD_W'(r_in_entry);
                r_used[entry_idx]     <= 1'b0;
                r_nf_valid[entry_idx] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: input latch, result staging, output.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_desc  <= s_axis_tdata[7:0];
            r_in_entry <= s_axis_tdata[14:8];
            r_in_inode <= s_axis_tdata[30:15];
            r_in_flags <= s_axis_tdata[46:31];
        end
        if (res_load) begin
            r_res_status <= n_res_status;
            r_res_entry  <= n_res_entry;
            r_res_inode  <= n_res_inode;
            r_res_flags  <= n_res_flags;
            r_res_rel    <= n_res_rel;
        end
        // The found descriptor is kept for the commit step; failures report zero.
        if (r_state == S_SCAN && scan_res.done) begin
            r_res_desc <= (scan_res.found && !head_null) ? scan_res.idx : '0;
        end else if (res_load) begin
            r_res_desc <= n_res_desc;
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_desc   <= r_res_desc;
            r_out_entry  <= r_res_entry;
            r_out_inode  <= r_res_inode;
            r_out_flags  <= r_res_flags;
            r_out_rel    <= r_res_rel;
        end
    end

    // Descriptor binding memory.
    always_ff @(posedge i_clk) begin
        if (alloc_commit) begin
            mem_bind[r_res_desc] <= head_idx;
        end
        r_bind_q <= mem_bind[desc_idx];
    end

    // Free list link memory; an entry never linked reads as its successor.
    always_ff @(posedge i_clk) begin
        if (close_commit) begin
            mem_next[entry_idx] <= r_head;
        end
        r_nf_mem_q  <= mem_next[head_idx];
        r_nf_v_q    <= r_nf_valid[head_idx];
        r_nf_dflt_q <= HEAD_W'(head_idx) + 1'b1;
    end

    // File entry contents.
    always_ff @(posedge i_clk) begin
        if (alloc_commit) begin
            mem_inode[head_idx] <= r_in_inode;
            mem_flags[head_idx] <= r_in_flags;
        end
        r_inode_q <= mem_inode[ent_rd_addr];
        r_flags_q <= mem_flags[ent_rd_addr];
    end

    // Output ports.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {OUT_PAD_W'(0), r_out_flags, r_out_inode, r_out_entry, r_out_desc};
    assign m_axis_tuser  = {r_out_rel, r_out_status};

    // The free list head never names an entry that is in use.
    `OFT_ASSERT_NOW(a_head_free, !head_null, !r_used[head_idx])
    // A successful allocation leaves the descriptor bound and the entry in use.
    `OFT_ASSERT_NEXT(a_alloc_bound, r_state == S_ALLOC_RD, r_bound[r_res_desc] && r_used[r_res_entry])
    // The last close puts the entry on top of the free list.
    `OFT_ASSERT_NEXT(a_close_push, close_commit, r_head == HEAD_W'($past(r_in_entry)) && !r_used[$past(entry_idx)])

endmodule
